FILE: sv/ojfd_pkg.sv
// Shared types and constants for the optical jam frequency detector.
package ojfd_pkg;

	localparam int PERIOD_BITS = 24;
	localparam int HOLD_BITS   = 32;
	localparam int CFG_W       = 32;
	localparam int CFG_IDX_W   = 2;

	localparam logic [PERIOD_BITS-1:0] PERIOD_MAX     = {PERIOD_BITS{1'b1}};
	localparam logic [PERIOD_BITS-1:0] TIMEOUT_RESET  = PERIOD_BITS'(100000);
	localparam logic [HOLD_BITS-1:0]   HOLD_RESET     = HOLD_BITS'(1000000);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MIN_PERIOD = 2'd0,
		CFG_MAX_PERIOD = 2'd1,
		CFG_TIMEOUT    = 2'd2,
		CFG_JAM_HOLD   = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		PH_SKIP_HIGH = 2'd0,
		PH_WAIT_RISE = 2'd1,
		PH_HIGH      = 2'd2,
		PH_LOW       = 2'd3
	} phase_t;

	typedef enum logic {
		OP_TICK = 1'b0,
		OP_BYTE = 1'b1
	} opcode_t;

	// jam status for the word being accepted
	typedef struct packed {
		logic detected;
		logic jammed;
	} jam_stat_t;

endpackage

FILE: sv/optical_jam_frequency_detector.sv
// Top level of the optical jam frequency detector.
// An accepted word's result is registered and shown on the master side in the cycle after it is accepted.
// Throughput: one word per cycle while the master side is ready; the result register frees as it is taken.
// Each word gives exactly one result word.
// Reset (arst_n low): window restarts skipping a high phase, jam hold cleared,
// no packet open, registers back to their defaults, result register empty.
module optical_jam_frequency_detector
	import ojfd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [15:0]          s_axis_tdata,  // light_high, byte_in[7:0], zero pad
	input  logic                 s_axis_tlast,  // byte_last
	input  logic                 s_axis_tuser,  // opcode
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [15:0]          m_axis_tdata,  // byte_out[7:0], jammed, jam_detected, zero pad
	output logic                 m_axis_tlast,  // byte_out_last
	output logic                 m_axis_tuser   // byte_valid
);

	logic      accept, tick_en, byte_en;
	jam_stat_t stat;
	logic      bv, blast;
	logic [7:0] bout;

	logic       out_valid_q;
	logic [7:0] byte_q;
	logic       last_q, valid_q, jammed_q, detected_q;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign tick_en       = accept && (opcode_t'(s_axis_tuser) == OP_TICK);
	assign byte_en       = accept && (opcode_t'(s_axis_tuser) == OP_BYTE);

	ojfd_window u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.tick_en    (tick_en),
		.light_high (s_axis_tdata[0]),
		.stat       (stat)
	);

	ojfd_gate u_gate (
		.clk           (clk),
		.arst_n        (arst_n),
		.byte_en       (byte_en),
		.jammed        (stat.jammed),
		.byte_in       (s_axis_tdata[8:1]),
		.byte_last     (s_axis_tlast),
		.byte_valid    (bv),
		.byte_out      (bout),
		.byte_out_last (blast)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (accept)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q     <= bout;
			last_q     <= blast;
			valid_q    <= bv;
			jammed_q   <= stat.jammed;
			detected_q <= stat.detected;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, detected_q, jammed_q, byte_q};
	assign m_axis_tlast  = last_q;
	assign m_axis_tuser  = valid_q;

endmodule

FILE: sv/ojfd_window.sv
// Measurement window, period check and jam hold counter.
module ojfd_window
	import ojfd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 tick_en,
	input  logic                 light_high,
	output jam_stat_t            stat
);

	logic [PERIOD_BITS-1:0] min_period_q, max_period_q, timeout_q;
	logic [HOLD_BITS-1:0]   jam_hold_q;

	phase_t                 phase_q, phase_n;
	logic [PERIOD_BITS-1:0] window_q, window_n, window_inc;
	logic [PERIOD_BITS-1:0] period_q, period_n, period_inc;
	logic [HOLD_BITS-1:0]   jam_q, jam_n;
	logic                   done, detected;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_period_q <= '0;
			max_period_q <= '0;
			timeout_q    <= TIMEOUT_RESET;
			jam_hold_q   <= HOLD_RESET;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_MIN_PERIOD: min_period_q <= cfg_data[PERIOD_BITS-1:0];
				CFG_MAX_PERIOD: max_period_q <= cfg_data[PERIOD_BITS-1:0];
				CFG_TIMEOUT:    timeout_q    <= cfg_data[PERIOD_BITS-1:0];
				CFG_JAM_HOLD:   jam_hold_q   <= cfg_data[HOLD_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign period_inc = (period_q == PERIOD_MAX) ? PERIOD_MAX : period_q + PERIOD_BITS'(1);
	assign window_inc = (window_q == PERIOD_MAX) ? PERIOD_MAX : window_q + PERIOD_BITS'(1);

	always_comb begin
		phase_n  = phase_q;
		period_n = period_q;
		window_n = window_inc;
		done     = 1'b0;
		detected = 1'b0;
		case (phase_q)
			PH_SKIP_HIGH: begin
				if (!light_high) phase_n = PH_WAIT_RISE;
			end
			PH_WAIT_RISE: begin
				if (light_high) begin
					phase_n  = PH_HIGH;
					period_n = '0;
				end
			end
			PH_HIGH: begin
				period_n = period_inc;
				if (!light_high) phase_n = PH_LOW;
			end
			PH_LOW: begin
				period_n = period_inc;
				if (light_high) begin
					done     = 1'b1;
					detected = (period_inc >= min_period_q) &&
						(period_inc <= max_period_q);
				end
			end
			default: ;
		endcase
		if (done || (window_inc >= timeout_q)) begin
			phase_n  = PH_SKIP_HIGH;
			window_n = '0;
			period_n = '0;
		end
		if (detected)
			jam_n = jam_hold_q;
		else if (jam_q != '0)
			jam_n = jam_q - HOLD_BITS'(1);
		else
			jam_n = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SKIP_HIGH;
			window_q <= '0;
			period_q <= '0;
			jam_q    <= '0;
		end else if (tick_en) begin
			phase_q  <= phase_n;
			window_q <= window_n;
			period_q <= period_n;
			jam_q    <= jam_n;
		end
	end

	// on a byte the hold counter is untouched, so current state is reported
	assign stat.detected = tick_en & detected;
	assign stat.jammed   = tick_en ? (jam_n != '0) : (jam_q != '0);

endmodule

FILE: sv/ojfd_gate.sv
// Packet gate: passes or drops a whole packet from the jam state at its first byte.
module ojfd_gate
	import ojfd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_en,
	input  logic       jammed,
	input  logic [7:0] byte_in,
	input  logic       byte_last,
	output logic       byte_valid,
	output logic [7:0] byte_out,
	output logic       byte_out_last
);

	logic in_packet_q, dropping_q, drop_now;

	assign drop_now = in_packet_q ? dropping_q : jammed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_packet_q <= 1'b0;
			dropping_q  <= 1'b0;
		end else if (byte_en) begin
			in_packet_q <= !byte_last;
			dropping_q  <= !byte_last && drop_now;
		end
	end

	assign byte_valid    = byte_en && !drop_now;
	assign byte_out      = byte_valid ? byte_in : 8'd0;
	assign byte_out_last = byte_valid && byte_last;

endmodule
